// ===== rtl/auw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// auw_pkg
// shared types and codes for the uart with fifos
// ----------------------------------------------------------------------------
package auw_pkg;

    typedef logic [7:0] byte_t;

    // bus access codes
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // register indexes
    localparam logic [5:0] REG_DATA   = 6'd0;
    localparam logic [5:0] REG_STATUS = 6'd1;
    localparam logic [5:0] REG_CTRL   = 6'd2;
    localparam logic [5:0] REG_SCALER = 6'd3;
    localparam logic [5:0] REG_DEBUG  = 6'd4;

    // control bit positions
    localparam int C_RXEN  = 0;
    localparam int C_TXEN  = 1;
    localparam int C_RIRQ  = 2;
    localparam int C_TIRQ  = 3;
    localparam int C_PSEL  = 4;
    localparam int C_PEN   = 5;
    localparam int C_FLOW  = 6;
    localparam int C_LOOP  = 7;
    localparam int C_EXTC  = 8;
    localparam int C_TFIRQ = 9;
    localparam int C_RFIRQ = 10;
    localparam int C_DEBUG = 11;
    localparam int C_BIRQ  = 12;
    localparam int C_DIRQ  = 13;
    localparam int C_TSIRQ = 14;

    // transmit frame phases
    localparam logic [1:0] TX_IDLE   = 2'd0;
    localparam logic [1:0] TX_DATA   = 2'd1;
    localparam logic [1:0] TX_PARITY = 2'd2;
    localparam logic [1:0] TX_STOP   = 2'd3;

    // receive frame phases
    localparam logic [2:0] RX_IDLE   = 3'd0;
    localparam logic [2:0] RX_START  = 3'd1;
    localparam logic [2:0] RX_DATA   = 3'd2;
    localparam logic [2:0] RX_PARITY = 3'd3;
    localparam logic [2:0] RX_STOP   = 3'd4;

    localparam logic [9:0] TX_LAST_BIT  = 10'h3FE;
    localparam logic [2:0] RX_SUB_START = 3'h4;
    localparam logic [1:0] DLY_FIRE     = 2'h3;

endpackage

`default_nettype wire

// ===== rtl/auw_fifo_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// auw_fifo_ram
// fifo storage, one write and one registered read port with write forwarding
// ----------------------------------------------------------------------------
module auw_fifo_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire                 clk,
    input  wire                 we,
    input  wire  [AW-1:0]       waddr,
    input  auw_pkg::byte_t      wdata,
    input  wire  [AW-1:0]       raddr,
    output auw_pkg::byte_t      rdata
);

    auw_pkg::byte_t mem [DEPTH];
    auw_pkg::byte_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // new data bypasses the array when it lands on the read address
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/apb_uart_with_fifos.sv =====
// a word's results come out of the output register in the cycle after it is taken
// throughput: one word per cycle; stall backs up only when the output register is held
// each fifo read is prefetched from its memory at the next pointer value, so pops keep full rate
// reset: rst_n clears all control state asynchronously; fifo memories are not cleared
`default_nettype none
// ----------------------------------------------------------------------------
// apb_uart_with_fifos
// uart with transmit and receive fifos behind a word register bank
// ----------------------------------------------------------------------------
module apb_uart_with_fifos #(
    parameter int FIFO_DEPTH  = 8,
    parameter int SCALER_BITS = 12
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [1:0]  cmd,
    input  wire  [5:0]  reg_index,
    input  wire  [31:0] write_data,
    input  wire         rx_line,
    input  wire         cts_n,
    input  wire         ext_clock,
    input  wire         clear_n,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [31:0] read_data,
    output logic        irq,
    output logic        tx_line,
    output logic        rts_n,
    output logic        tx_enabled,
    output logic        rx_enabled,
    output logic [11:0] scaler_value
);

    localparam int PW  = $clog2(FIFO_DEPTH);       // fifo pointer width
    localparam int CW  = $clog2(FIFO_DEPTH + 1);   // fifo count width
    localparam int CNW = CW + 1;                   // count before saturation
    localparam int SB  = SCALER_BITS;

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    logic [SB-1:0]  baud_reload_reg, baud_reload_next;
    logic [SB-1:0]  baud_count_reg, baud_count_next;
    logic [CW-1:0]  tx_count_reg, tx_count_next;
    logic [CW-1:0]  rx_count_reg, rx_count_next;
    logic [PW-1:0]  rr_ptr_reg, rr_ptr_next;
    logic [PW-1:0]  rw_ptr_reg, rw_ptr_next;
    logic [PW-1:0]  tr_ptr_reg, tr_ptr_next;
    logic [PW-1:0]  tw_ptr_reg, tw_ptr_next;
    logic [10:0]    tx_shift_reg, tx_shift_next;
    logic [7:0]     rx_shift_reg, rx_shift_next;
    logic [1:0]     tx_phase_reg, tx_phase_next;
    logic [2:0]     rx_phase_reg, rx_phase_next;
    logic [2:0]     tx_sub_reg, tx_sub_next;
    logic [2:0]     rx_sub_reg, rx_sub_next;
    logic [4:0]     rx_filter_reg, rx_filter_next;
    logic [1:0]     cts_sync_reg, cts_sync_next;
    logic [1:0]     rxd_sync_reg, rxd_sync_next;
    logic [14:0]    ctrl_reg, ctrl_next;
    logic           rse_reg, rse_next;         // rx shifter empty
    logic           tse_reg, tse_next;         // tx shifter empty
    logic           brk_reg, brk_next;
    logic           ovf_reg, ovf_next;
    logic           par_reg, par_next;
    logic           frm_reg, frm_next;
    logic           tx_par_reg, tx_par_next;
    logic           rx_par_reg, rx_par_next;
    logic [5:0]     dly_reg, dly_next;
    logic           tick_reg, tick_next;
    logic           txt_reg, txt_next;
    logic           rxt_reg, rxt_next;
    logic           ext_reg, ext_next;
    logic           rts_reg, rts_next;
    logic           txd_reg, txd_next;
    logic           irq_reg, irq_next;
    logic           pend_reg, pend_next;

    // output register
    logic           out_valid_reg;
    logic [31:0]    read_data_reg;
    logic           irq_out_reg, tx_line_reg, rts_n_reg, tx_en_reg, rx_en_reg;
    logic [11:0]    scaler_reg;

    // fifo memory ports
    logic           tx_we, rx_we;
    auw_pkg::byte_t tx_wdata, rx_wdata, tx_q, rx_q;
    logic [PW-1:0]  tx_raddr, rx_raddr;

    logic           accept;
    logic [31:0]    rdata;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        begin
            if (p == PW'(FIFO_DEPTH - 1))
            begin
                r = '0;
            end
            else
            begin
                r = p + 1'b1;
            end
            return r;
        end
    endfunction

    // a word moves when the output register is free or being drained
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // fifo memories; read address follows the next value of the pointer when a word is taken, else the pointer
    // ------------------------------------------------------------------
    assign tx_raddr = accept ? tr_ptr_next : tr_ptr_reg;
    assign rx_raddr = accept ? rr_ptr_next : rr_ptr_reg;

    auw_fifo_ram #(.DEPTH(FIFO_DEPTH), .AW(PW)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we && accept),
        .waddr (tw_ptr_reg),
        .wdata (tx_wdata),
        .raddr (tx_raddr),
        .rdata (tx_q)
    );

    auw_fifo_ram #(.DEPTH(FIFO_DEPTH), .AW(PW)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we && accept),
        .waddr (rw_ptr_reg),
        .wdata (rx_wdata),
        .raddr (rx_raddr),
        .rdata (rx_q)
    );

    // ------------------------------------------------------------------
    // next-state logic of the uart
    // ------------------------------------------------------------------
    always_comb
    begin
        logic          rd, wr;
        logic          tfull, rfull, rhalf, thalf, dready, thempty;
        logic [SB-1:0] sc;
        logic          tick, irq_acc, ctsn, rxd, maj, dp;
        logic [2:0]    t0, t1;
        logic [CNW-1:0] txc, rxc;

        rd      = (cmd == auw_pkg::CMD_READ);
        wr      = (cmd == auw_pkg::CMD_WRITE);
        tfull   = (CNW'(tx_count_reg) >= CNW'(FIFO_DEPTH));
        rfull   = (CNW'(rx_count_reg) >= CNW'(FIFO_DEPTH));
        rhalf   = ({rx_count_reg, 1'b0} >= CNW'(FIFO_DEPTH));
        thalf   = !({tx_count_reg, 1'b0} >= CNW'(FIFO_DEPTH));
        dready  = (rx_count_reg != '0);
        thempty = (tx_count_reg == '0);
        irq_acc = 1'b0;
        rdata   = '0;
        txc     = CNW'(tx_count_reg);
        rxc     = CNW'(rx_count_reg);
        tx_we    = 1'b0;
        rx_we    = 1'b0;
        tx_wdata = write_data[7:0];
        rx_wdata = write_data[7:0];

        baud_reload_next = baud_reload_reg;
        baud_count_next  = baud_count_reg;
        rr_ptr_next      = rr_ptr_reg;
        rw_ptr_next      = rw_ptr_reg;
        tr_ptr_next      = tr_ptr_reg;
        tw_ptr_next      = tw_ptr_reg;
        tx_shift_next    = tx_shift_reg;
        rx_shift_next    = rx_shift_reg;
        tx_phase_next    = tx_phase_reg;
        rx_phase_next    = rx_phase_reg;
        tx_sub_next      = tx_sub_reg;
        rx_sub_next      = rx_sub_reg;
        ctrl_next        = ctrl_reg;
        rse_next         = rse_reg;
        tse_next         = tse_reg;
        brk_next         = brk_reg;
        ovf_next         = ovf_reg;
        par_next         = par_reg;
        frm_next         = frm_reg;
        tx_par_next      = tx_par_reg;
        rx_par_next      = rx_par_reg;
        dly_next         = dly_reg;
        rts_next         = rts_reg;
        pend_next        = pend_reg;
        txt_next         = 1'b0;
        rxt_next         = 1'b0;

        // synchronizers
        cts_sync_next = {cts_sync_reg[0], cts_n};
        rxd_sync_next = {rxd_sync_reg[0], rxd_sync_reg[0]};

        // baud scaler and tick
        sc   = baud_count_reg - 1'b1;
        tick = 1'b0;
        if (ctrl_reg[auw_pkg::C_RXEN] || ctrl_reg[auw_pkg::C_TXEN])
        begin
            baud_count_next = sc;
            tick = sc[SB-1] && !baud_count_reg[SB-1];
            if (tick)
            begin
                baud_count_next = baud_reload_reg;
            end
        end
        ext_next = ext_clock;
        if (ctrl_reg[auw_pkg::C_EXTC])
        begin
            tick = ext_reg && !ext_clock;
        end
        tick_next = tick;

        // bus reads
        if (rd)
        begin
            unique case (reg_index)
                auw_pkg::REG_DATA:
                begin
                    rdata = {24'd0, rx_q};
                    if (dready)
                    begin
                        rr_ptr_next = ptr_inc(rr_ptr_reg);
                        rxc = CNW'(rx_count_reg) - 1'b1;
                    end
                end
                auw_pkg::REG_STATUS:
                begin
                    rdata = {6'(rx_count_reg), 6'(tx_count_reg), 9'd0, rfull, tfull,
                             rhalf, thalf, frm_reg, par_reg, ovf_reg, brk_reg,
                             thempty, tse_reg, dready};
                end
                auw_pkg::REG_CTRL:
                begin
                    rdata = {1'b1, 16'd0, ctrl_reg};
                end
                auw_pkg::REG_SCALER:
                begin
                    rdata = 32'(baud_reload_reg);
                end
                auw_pkg::REG_DEBUG:
                begin
                    if (ctrl_reg[auw_pkg::C_DEBUG] && !thempty)
                    begin
                        rdata = {24'd0, tx_q};
                        tr_ptr_next = ptr_inc(tr_ptr_reg);
                        txc = CNW'(tx_count_reg) - 1'b1;
                    end
                end
                default:
                begin
                    rdata = '0;
                end
            endcase
        end

        // bus writes
        if (wr)
        begin
            unique case (reg_index)
                auw_pkg::REG_STATUS:
                begin
                    frm_next = write_data[6];
                    par_next = write_data[5];
                    ovf_next = write_data[4];
                    brk_next = write_data[3];
                end
                auw_pkg::REG_CTRL:
                begin
                    ctrl_next = write_data[14:0];
                end
                auw_pkg::REG_SCALER:
                begin
                    baud_reload_next = write_data[SB-1:0];
                    baud_count_next  = write_data[SB-1:0];
                end
                auw_pkg::REG_DEBUG:
                begin
                    rx_we       = 1'b1;
                    rx_wdata    = write_data[7:0];
                    rw_ptr_next = ptr_inc(rw_ptr_reg);
                    rxc         = rxc + 1'b1;
                    if (ctrl_reg[auw_pkg::C_DEBUG])
                    begin
                        irq_acc = irq_acc | ctrl_reg[auw_pkg::C_RIRQ];
                    end
                end
                default:
                begin
                end
            endcase
        end

        // bit ticks, one per eight baud ticks
        if (tick_reg)
        begin
            t0 = tx_sub_reg + 1'b1;
            t1 = rx_sub_reg + 1'b1;
            tx_sub_next = t0;
            rx_sub_next = t1;
            txt_next = tx_sub_reg[2] && !t0[2];
            rxt_next = rx_sub_reg[2] && !t1[2];
        end
        if (rxt_reg && ctrl_reg[auw_pkg::C_DIRQ])
        begin
            dly_next = dly_next + 1'b1;
        end
        if (dly_reg[5:4] == auw_pkg::DLY_FIRE)
        begin
            irq_acc   = irq_acc | (ctrl_reg[auw_pkg::C_DIRQ] && pend_reg);
            pend_next = 1'b0;
        end

        // receive filter, majority of three samples
        rx_filter_next = {rx_filter_reg[4:2], rx_filter_reg[0], rx_line};
        if (tick_reg)
        begin
            rx_filter_next[4:2] = rx_filter_reg[3:1];
        end
        maj = (rx_filter_reg[4] && rx_filter_reg[3]) || (rx_filter_reg[4] && rx_filter_reg[2])
              || (rx_filter_reg[3] && rx_filter_reg[2]);
        if (ctrl_reg[auw_pkg::C_LOOP])
        begin
            maj  = tx_shift_reg[0];
            ctsn = dready && !rse_reg;
        end
        else
        begin
            ctsn = cts_sync_reg[1];
        end
        rxd_sync_next[0] = maj;
        rxd = rxd_sync_reg[0];

        // transmit frame
        unique case (tx_phase_reg)
            auw_pkg::TX_IDLE:
            begin
                if (txt_reg)
                begin
                    tse_next = 1'b1;
                end
                if (!ctrl_reg[auw_pkg::C_DEBUG] && ctrl_reg[auw_pkg::C_TXEN] && !thempty
                    && txt_reg && (!ctsn || !ctrl_reg[auw_pkg::C_FLOW]))
                begin
                    tx_phase_next = auw_pkg::TX_DATA;
                    tx_par_next   = ctrl_reg[auw_pkg::C_PSEL];
                    tse_next      = 1'b0;
                    tx_sub_next   = {2'b00, tick_reg};
                    txt_next      = 1'b0;
                    tx_shift_next = {2'b01, tx_q, 1'b0};
                    tr_ptr_next   = ptr_inc(tr_ptr_reg);
                    txc           = CNW'(tx_count_reg) - 1'b1;
                end
            end
            auw_pkg::TX_DATA:
            begin
                if (txt_reg)
                begin
                    tx_par_next   = tx_par_reg ^ tx_shift_reg[1];
                    tx_shift_next = {1'b1, tx_shift_reg[10:1]};
                    if (tx_shift_reg[10:1] == auw_pkg::TX_LAST_BIT)
                    begin
                        if (ctrl_reg[auw_pkg::C_PEN])
                        begin
                            tx_shift_next[0] = tx_par_reg;
                            tx_phase_next    = auw_pkg::TX_PARITY;
                        end
                        else
                        begin
                            tx_shift_next[0] = 1'b1;
                            tx_phase_next    = auw_pkg::TX_STOP;
                        end
                    end
                end
            end
            default:
            begin
                if (txt_reg)
                begin
                    tx_shift_next = {1'b1, tx_shift_reg[10:1]};
                    tx_phase_next = (tx_phase_reg == auw_pkg::TX_PARITY) ?
                                    auw_pkg::TX_STOP : auw_pkg::TX_IDLE;
                end
            end
        endcase

        // data register write pushes the transmit fifo (low index bits decode)
        if (wr && (reg_index[2:0] == 3'd0))
        begin
            tx_we    = 1'b1;
            tx_wdata = write_data[7:0];
            if (!tfull)
            begin
                tw_ptr_next = ptr_inc(tw_ptr_reg);
                txc = txc + 1'b1;
            end
        end

        // receive frame
        unique case (rx_phase_reg)
            auw_pkg::RX_IDLE:
            begin
                if (!rse_reg && !rfull)
                begin
                    rse_next    = 1'b1;
                    rx_we       = 1'b1;
                    rx_wdata    = rx_shift_reg;
                    rw_ptr_next = ptr_inc(rw_ptr_reg);
                    rxc         = rxc + 1'b1;
                end
                if (ctrl_reg[auw_pkg::C_RXEN] && rxd_sync_reg[1] && !rxd)
                begin
                    rx_phase_next = auw_pkg::RX_START;
                    rx_shift_next = 8'hFF;
                    rx_sub_next   = auw_pkg::RX_SUB_START;
                    if (!rse_next)
                    begin
                        ovf_next = 1'b1;
                    end
                    rse_next = 1'b0;
                    rxt_next = 1'b0;
                end
            end
            auw_pkg::RX_START:
            begin
                if (rxt_reg)
                begin
                    if (!rxd)
                    begin
                        rx_shift_next = {1'b0, rx_shift_reg[7:1]};
                        rx_phase_next = auw_pkg::RX_DATA;
                        rx_par_next   = ctrl_reg[auw_pkg::C_PSEL];
                    end
                    else
                    begin
                        rx_phase_next = auw_pkg::RX_IDLE;
                    end
                end
            end
            auw_pkg::RX_DATA:
            begin
                if (rxt_reg)
                begin
                    rx_par_next   = rx_par_reg ^ rxd;
                    rx_shift_next = {rxd, rx_shift_reg[7:1]};
                    if (!rx_shift_reg[0])
                    begin
                        if (ctrl_reg[auw_pkg::C_PEN])
                        begin
                            rx_phase_next = auw_pkg::RX_PARITY;
                        end
                        else
                        begin
                            rx_phase_next = auw_pkg::RX_STOP;
                            rx_par_next   = 1'b0;
                        end
                    end
                end
            end
            auw_pkg::RX_PARITY:
            begin
                if (rxt_reg)
                begin
                    rx_par_next   = rx_par_reg ^ rxd;
                    rx_phase_next = auw_pkg::RX_STOP;
                end
            end
            auw_pkg::RX_STOP:
            begin
                if (rxt_reg)
                begin
                    dp = rx_par_reg;
                    if (!ctrl_reg[auw_pkg::C_DIRQ])
                    begin
                        irq_acc = irq_acc | ctrl_reg[auw_pkg::C_RIRQ];
                    end
                    if (rxd)
                    begin
                        if (ctrl_reg[auw_pkg::C_DIRQ])
                        begin
                            pend_next = ctrl_reg[auw_pkg::C_RIRQ];
                            dly_next  = '0;
                        end
                        par_next = par_reg | dp;
                        rse_next = dp;
                        if (!rfull && !dp)
                        begin
                            rse_next    = 1'b1;
                            rx_we       = 1'b1;
                            rx_wdata    = rx_shift_reg;
                            rw_ptr_next = ptr_inc(rw_ptr_reg);
                            rxc         = rxc + 1'b1;
                        end
                    end
                    else
                    begin
                        if (rx_shift_reg == 8'd0)
                        begin
                            brk_next = 1'b1;
                            irq_acc  = irq_acc | ctrl_reg[auw_pkg::C_BIRQ];
                        end
                        else
                        begin
                            frm_next = 1'b1;
                        end
                        rse_next = 1'b1;
                    end
                    rx_phase_next = auw_pkg::RX_IDLE;
                end
            end
            default:
            begin
                rx_phase_next = auw_pkg::RX_IDLE;
            end
        endcase

        // counts saturate at the fifo depth
        if (rxc > CNW'(FIFO_DEPTH))
        begin
            rxc = CNW'(FIFO_DEPTH);
        end
        if (txc > CNW'(FIFO_DEPTH))
        begin
            txc = CNW'(FIFO_DEPTH);
        end
        rx_count_next = rxc[CW-1:0];
        tx_count_next = txc[CW-1:0];

        if (rxt_reg)
        begin
            rts_next = (rfull && !rse_reg) || ctrl_reg[auw_pkg::C_LOOP];
        end
        txd_next = tx_shift_reg[0] || ctrl_reg[auw_pkg::C_LOOP] || ctrl_reg[auw_pkg::C_DEBUG];

        // interrupt sources
        if (!thempty && (txc == '0))
        begin
            irq_acc = irq_acc | ctrl_reg[auw_pkg::C_TIRQ];
        end
        irq_acc = irq_acc | (ctrl_reg[auw_pkg::C_TFIRQ] && ctrl_reg[auw_pkg::C_TXEN] && thalf);
        if (ctrl_reg[auw_pkg::C_RFIRQ] && ctrl_reg[auw_pkg::C_RXEN] && rhalf)
        begin
            irq_acc   = 1'b1;
            pend_next = 1'b0;
        end
        irq_acc = irq_acc | (ctrl_reg[auw_pkg::C_TSIRQ] && tse_next && !tse_reg);
        irq_next = irq_acc;

        // synchronous clear request
        if (!clear_n)
        begin
            rse_next = 1'b1;
            tse_next = 1'b1;
            brk_next = 1'b0;
            ovf_next = 1'b0;
            par_next = 1'b0;
            frm_next = 1'b0;
            ctrl_next[auw_pkg::C_TXEN] = 1'b0;
            ctrl_next[auw_pkg::C_RXEN] = 1'b0;
            ctrl_next[auw_pkg::C_EXTC] = 1'b0;
            ctrl_next[auw_pkg::C_FLOW] = 1'b0;
            tx_phase_next    = auw_pkg::TX_IDLE;
            rx_phase_next    = auw_pkg::RX_IDLE;
            tx_shift_next[0] = 1'b1;
            rts_next    = 1'b1;
            pend_next   = 1'b0;
            tx_sub_next = '0;
            rx_sub_next = '0;
            rx_count_next = '0;
            tx_count_next = '0;
            rr_ptr_next = '0;
            rw_ptr_next = '0;
            tr_ptr_next = '0;
            tw_ptr_next = '0;
            dly_next    = '0;
        end
    end

    // ------------------------------------------------------------------
    // state update, only when a word is taken
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baud_reload_reg <= '0;
            baud_count_reg  <= '0;
            tx_count_reg    <= '0;
            rx_count_reg    <= '0;
            rr_ptr_reg      <= '0;
            rw_ptr_reg      <= '0;
            tr_ptr_reg      <= '0;
            tw_ptr_reg      <= '0;
            tx_shift_reg    <= 11'd1;
            rx_shift_reg    <= '0;
            tx_phase_reg    <= auw_pkg::TX_IDLE;
            rx_phase_reg    <= auw_pkg::RX_IDLE;
            tx_sub_reg      <= '0;
            rx_sub_reg      <= '0;
            rx_filter_reg   <= '0;
            cts_sync_reg    <= '0;
            rxd_sync_reg    <= '0;
            ctrl_reg        <= '0;
            rse_reg         <= 1'b1;
            tse_reg         <= 1'b1;
            brk_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            par_reg         <= 1'b0;
            frm_reg         <= 1'b0;
            tx_par_reg      <= 1'b0;
            rx_par_reg      <= 1'b0;
            dly_reg         <= '0;
            tick_reg        <= 1'b0;
            txt_reg         <= 1'b0;
            rxt_reg         <= 1'b0;
            ext_reg         <= 1'b0;
            rts_reg         <= 1'b1;
            txd_reg         <= 1'b1;
            irq_reg         <= 1'b0;
            pend_reg        <= 1'b0;
        end
        else if (accept)
        begin
            baud_reload_reg <= baud_reload_next;
            baud_count_reg  <= baud_count_next;
            tx_count_reg    <= tx_count_next;
            rx_count_reg    <= rx_count_next;
            rr_ptr_reg      <= rr_ptr_next;
            rw_ptr_reg      <= rw_ptr_next;
            tr_ptr_reg      <= tr_ptr_next;
            tw_ptr_reg      <= tw_ptr_next;
            tx_shift_reg    <= tx_shift_next;
            rx_shift_reg    <= rx_shift_next;
            tx_phase_reg    <= tx_phase_next;
            rx_phase_reg    <= rx_phase_next;
            tx_sub_reg      <= tx_sub_next;
            rx_sub_reg      <= rx_sub_next;
            rx_filter_reg   <= rx_filter_next;
            cts_sync_reg    <= cts_sync_next;
            rxd_sync_reg    <= rxd_sync_next;
            ctrl_reg        <= ctrl_next;
            rse_reg         <= rse_next;
            tse_reg         <= tse_next;
            brk_reg         <= brk_next;
            ovf_reg         <= ovf_next;
            par_reg         <= par_next;
            frm_reg         <= frm_next;
            tx_par_reg      <= tx_par_next;
            rx_par_reg      <= rx_par_next;
            dly_reg         <= dly_next;
            tick_reg        <= tick_next;
            txt_reg         <= txt_next;
            rxt_reg         <= rxt_next;
            ext_reg         <= ext_next;
            rts_reg         <= rts_next;
            txd_reg         <= txd_next;
            irq_reg         <= irq_next;
            pend_reg        <= pend_next;
        end
    end

    // ------------------------------------------------------------------
    // output register: pins show the state from before this word
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= rdata;
            irq_out_reg   <= irq_reg;
            tx_line_reg   <= txd_reg;
            rts_n_reg     <= rts_reg;
            tx_en_reg     <= ctrl_reg[auw_pkg::C_TXEN];
            rx_en_reg     <= ctrl_reg[auw_pkg::C_RXEN];
            scaler_reg    <= baud_count_reg[11:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign irq          = irq_out_reg;
    assign tx_line      = tx_line_reg;
    assign rts_n        = rts_n_reg;
    assign tx_enabled   = tx_en_reg;
    assign rx_enabled   = rx_en_reg;
    assign scaler_value = scaler_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with empty output register");

    a_tx_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNW'(tx_count_reg) <= CNW'(FIFO_DEPTH))
        else $error("tx fifo count beyond depth");

    a_rx_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNW'(rx_count_reg) <= CNW'(FIFO_DEPTH))
        else $error("rx fifo count beyond depth");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(rx_count_reg) && $stable(tx_count_reg))
        else $error("fifo counts moved without a word");
`endif

endmodule

`default_nettype wire
